// ===== src/pse_pkg.sv =====
// Shared types and constants for the sound-effect sequencer.
// No dependencies; every other file in src imports this package.
package pse_pkg;

  localparam int unsigned JOB_WRITES  = 11;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_TRIGGER = 2'd1,
    KIND_STOP    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    FX_NONE      = 3'd0,
    FX_EXP_ENEMY = 3'd1,
    FX_EXP_SHIP  = 3'd2,
    FX_SHOT      = 3'd3,
    FX_BEEP      = 3'd4,
    FX_GAMEOVER  = 3'd5,
    FX_BOSSWARN  = 3'd6,
    FX_LEVELUP   = 3'd7
  } effect_e;

  // Sound generator register numbers.
  localparam logic [3:0] REG_TONE_A_LO = 4'd0;
  localparam logic [3:0] REG_TONE_A_HI = 4'd1;
  localparam logic [3:0] REG_TONE_B_LO = 4'd2;
  localparam logic [3:0] REG_TONE_B_HI = 4'd3;
  localparam logic [3:0] REG_TONE_C_LO = 4'd4;
  localparam logic [3:0] REG_TONE_C_HI = 4'd5;
  localparam logic [3:0] REG_NOISE     = 4'd6;
  localparam logic [3:0] REG_MIXER     = 4'd7;
  localparam logic [3:0] REG_VOL_A     = 4'd8;
  localparam logic [3:0] REG_VOL_B     = 4'd9;
  localparam logic [3:0] REG_VOL_C     = 4'd10;

  localparam logic [7:0] MIXER_ALL_OFF = 8'h3F;
  localparam logic [7:0] NOISE_IDLE    = 8'h1F;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] effect;
  } in_t;

  typedef struct packed {
    logic [3:0] reg_addr;
    logic [7:0] reg_value;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] value;
  } write_t;

  // One job: an ordered list of register writes, cnt of them valid.
  typedef struct packed {
    logic [3:0]                 cnt;
    write_t [JOB_WRITES-1:0]    w;
  } job_t;

endpackage

// ===== src/psg_sound_effect_sequencer_top.sv =====
// Top level of the three-channel sound-effect sequencer.
// Depends on pse_pkg, pse_front, pse_queue and pse_back.

// Each accepted input is a frame tick, an effect trigger or a stop-all. The
// front end takes one input per cycle whenever the job queue has room: a
// trigger only updates the channel state and produces no output, while a tick
// or a stop-all is turned in that same cycle into a complete list of register
// writes and pushed into a two-entry job queue. The serializer then delivers
// the list one write per cycle whenever the output is ready, through a
// registered output; a tick list holds 4 to 11 writes and a stop-all list
// exactly 11, and the output port is the only thing that sets the sustained
// rate. The last write of every list carries last set, which is the mixer
// word for a tick and the noise period for a stop-all. There are no
// configuration registers, and after reset all channels are idle.
module psg_sound_effect_sequencer_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pse_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pse_pkg::out_t out_data_o
);
  import pse_pkg::*;

  logic queue_full;
  logic push;
  logic pop;
  logic head_valid;
  job_t push_job;
  job_t head_job;

  // Front end: channel state and write-list construction.
  pse_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  // Job queue that lets the front keep accepting while writes drain.
  pse_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_job),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_job),
    .full_o       (queue_full)
  );

  // Serializer: one register write per cycle while the output is ready.
  pse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // The serializer only retires a job that is really in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> head_valid)
    else $error("job popped from an empty queue");

  // Writes never address a register beyond the generator's last one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.reg_addr <= REG_VOL_C)
    else $error("write to a nonexistent generator register");

  // A list always ends in the mixer word (tick) or the noise period (stop-all).
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |->
      out_data_o.reg_addr == REG_MIXER || out_data_o.reg_addr == REG_NOISE)
    else $error("final write of a list has an unexpected register");

  // No job is pushed into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !queue_full)
    else $error("job pushed into a full queue");

endmodule

// ===== src/pse_front.sv =====
// Front end: accepts input items, holds the channel state and turns each
// tick or stop-all into a write list job. Depends on pse_pkg.
module pse_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pse_pkg::in_t  in_data_i,
  input  logic          queue_full_i,
  output logic          push_o,
  output pse_pkg::job_t job_o
);
  import pse_pkg::*;

  typedef struct packed {
    logic [2:0]   cnt;
    write_t [3:0] w;
  } chan_t;

  localparam logic [7:0] EnemyNoise [5] = '{8'h04, 8'h07, 8'h0B, 8'h10, 8'h16};
  localparam logic [7:0] EnemyVol   [5] = '{8'd13, 8'd11, 8'd9, 8'd6, 8'd3};
  localparam logic [7:0] ShipTone   [7] = '{8'd220, 8'd180, 8'd150, 8'd120, 8'd90,
                                            8'd70, 8'd50};
  localparam logic [7:0] ShipVol    [7] = '{8'd15, 8'd14, 8'd12, 8'd10, 8'd8, 8'd6, 8'd4};
  localparam logic [7:0] ShipNoise  [7] = '{8'h04, 8'h06, 8'h08, 8'h0C, 8'h12, 8'h16,
                                            8'h1B};

  function automatic chan_t one_w(logic [3:0] a, logic [7:0] v);
    chan_t c;
    c          = '0;
    c.cnt      = 3'd1;
    c.w[0]     = '{addr: a, value: v};
    return c;
  endfunction

  function automatic chan_t tone_w(logic [3:0] lo_reg, logic [3:0] vol_reg,
                                   logic [7:0] lo, logic [7:0] hi, logic [7:0] vol);
    chan_t c;
    c      = '0;
    c.cnt  = 3'd3;
    c.w[0] = '{addr: lo_reg, value: lo};
    c.w[1] = '{addr: lo_reg + 4'd1, value: hi};
    c.w[2] = '{addr: vol_reg, value: vol};
    return c;
  endfunction

  effect_e    a_eff_q, b_eff_q, c_eff_q, a_eff_d, b_eff_d, c_eff_d;
  logic [4:0] a_frm_q, b_frm_q, c_frm_q, a_frm_d, b_frm_d, c_frm_d;
  effect_e    a_eff_nx, b_eff_nx, c_eff_nx;
  logic [4:0] a_frm_nx, b_frm_nx, c_frm_nx;
  chan_t      ch_a, ch_b, ch_c;
  logic       a_done, b_done, c_done, a_play, b_play, c_play;
  logic [7:0] mix;
  logic       accept;
  logic [3:0] n_b, n_c, n_m;
  job_t       tick_job, stop_job;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Channel A: tone A and volume A.
  always_comb begin
    ch_a     = '0;
    a_eff_nx = a_eff_q;
    a_frm_nx = a_frm_q;
    a_done   = 1'b0;
    a_play   = 1'b1;
    case (a_eff_q)
      FX_BEEP: begin
        if (a_frm_q < 5'd2)       ch_a = tone_w(REG_TONE_A_LO, REG_VOL_A, 8'd239, 8'd0, 8'd15);
        else if (a_frm_q == 5'd2) ch_a = one_w(REG_VOL_A, 8'd0);
        else if (a_frm_q < 5'd5)  ch_a = tone_w(REG_TONE_A_LO, REG_VOL_A, 8'd190, 8'd0, 8'd15);
        else                      a_done = 1'b1;
      end
      FX_LEVELUP: begin
        if (a_frm_q < 5'd2)       ch_a = tone_w(REG_TONE_A_LO, REG_VOL_A, 8'd239, 8'd0, 8'd14);
        else if (a_frm_q < 5'd4)  ch_a = tone_w(REG_TONE_A_LO, REG_VOL_A, 8'd190, 8'd0, 8'd14);
        else if (a_frm_q < 5'd6)  ch_a = tone_w(REG_TONE_A_LO, REG_VOL_A, 8'd160, 8'd0, 8'd13);
        else if (a_frm_q < 5'd8)  ch_a = tone_w(REG_TONE_A_LO, REG_VOL_A, 8'd119, 8'd0, 8'd15);
        else if (a_frm_q < 5'd11) ch_a = tone_w(REG_TONE_A_LO, REG_VOL_A, 8'd119, 8'd0, 8'd7);
        else                      a_done = 1'b1;
      end
      FX_GAMEOVER: begin
        if (a_frm_q < 5'd24) ch_a = tone_w(REG_TONE_A_LO, REG_VOL_A, 8'd28, 8'd1, 8'd12);
        else                 a_done = 1'b1;
      end
      FX_BOSSWARN: begin
        if (a_frm_q < 5'd2)       ch_a = tone_w(REG_TONE_A_LO, REG_VOL_A, 8'd95, 8'd1, 8'd13);
        else if (a_frm_q == 5'd2) ch_a = tone_w(REG_TONE_A_LO, REG_VOL_A, 8'd60, 8'd1, 8'd11);
        else if (a_frm_q == 5'd3) ch_a = one_w(REG_VOL_A, 8'd0);
        else if (a_frm_q < 5'd6)  ch_a = tone_w(REG_TONE_A_LO, REG_VOL_A, 8'd95, 8'd1, 8'd9);
        else                      a_done = 1'b1;
      end
      default: begin
        ch_a   = one_w(REG_VOL_A, 8'd0);
        a_play = 1'b0;
      end
    endcase
    if (a_done) begin
      a_eff_nx = FX_NONE;
      a_frm_nx = 5'd0;
      ch_a     = one_w(REG_VOL_A, 8'd0);
    end else if (a_play) begin
      a_frm_nx = a_frm_q + 5'd1;
    end
  end

  // Channel B: tone B, volume B and the shared noise period.
  always_comb begin
    ch_b     = '0;
    b_eff_nx = b_eff_q;
    b_frm_nx = b_frm_q;
    b_done   = 1'b0;
    b_play   = 1'b1;
    case (b_eff_q)
      FX_EXP_ENEMY: begin
        if (b_frm_q < 5'd5) begin
          ch_b.cnt  = 3'd2;
          ch_b.w[0] = '{addr: REG_NOISE, value: EnemyNoise[b_frm_q[2:0]]};
          ch_b.w[1] = '{addr: REG_VOL_B, value: EnemyVol[b_frm_q[2:0]]};
        end else begin
          b_done = 1'b1;
        end
      end
      FX_EXP_SHIP: begin
        if (b_frm_q < 5'd7) begin
          ch_b      = tone_w(REG_TONE_B_LO, REG_VOL_B, ShipTone[b_frm_q[2:0]], 8'd0,
                             ShipVol[b_frm_q[2:0]]);
          ch_b.cnt  = 3'd4;
          ch_b.w[3] = '{addr: REG_NOISE, value: ShipNoise[b_frm_q[2:0]]};
        end else begin
          b_done = 1'b1;
        end
      end
      FX_BEEP: begin
        if (b_frm_q < 5'd2)       ch_b = tone_w(REG_TONE_B_LO, REG_VOL_B, 8'd190, 8'd0, 8'd12);
        else if (b_frm_q == 5'd2) ch_b = one_w(REG_VOL_B, 8'd0);
        else if (b_frm_q < 5'd5)  ch_b = tone_w(REG_TONE_B_LO, REG_VOL_B, 8'd159, 8'd0, 8'd12);
        else                      b_done = 1'b1;
      end
      FX_GAMEOVER: begin
        if (b_frm_q < 5'd24) ch_b = tone_w(REG_TONE_B_LO, REG_VOL_B, 8'd239, 8'd0, 8'd12);
        else                 b_done = 1'b1;
      end
      default: begin
        ch_b   = one_w(REG_VOL_B, 8'd0);
        b_play = 1'b0;
      end
    endcase
    if (b_done) begin
      b_eff_nx = FX_NONE;
      b_frm_nx = 5'd0;
      ch_b     = one_w(REG_VOL_B, 8'd0);
    end else if (b_play) begin
      b_frm_nx = b_frm_q + 5'd1;
    end
  end

  // Channel C: tone C and volume C.
  always_comb begin
    ch_c     = '0;
    c_eff_nx = c_eff_q;
    c_frm_nx = c_frm_q;
    c_done   = 1'b0;
    c_play   = 1'b1;
    case (c_eff_q)
      FX_SHOT: begin
        if (c_frm_q == 5'd0)      ch_c = tone_w(REG_TONE_C_LO, REG_VOL_C, 8'd160, 8'd0, 8'd9);
        else if (c_frm_q == 5'd1) ch_c = tone_w(REG_TONE_C_LO, REG_VOL_C, 8'd112, 8'd0, 8'd4);
        else                      c_done = 1'b1;
      end
      FX_GAMEOVER: begin
        if (c_frm_q < 5'd24) ch_c = tone_w(REG_TONE_C_LO, REG_VOL_C, 8'd190, 8'd0, 8'd12);
        else                 c_done = 1'b1;
      end
      default: begin
        ch_c   = one_w(REG_VOL_C, 8'd0);
        c_play = 1'b0;
      end
    endcase
    if (c_done) begin
      c_eff_nx = FX_NONE;
      c_frm_nx = 5'd0;
      ch_c     = one_w(REG_VOL_C, 8'd0);
    end else if (c_play) begin
      c_frm_nx = c_frm_q + 5'd1;
    end
  end

  // The mixer word reflects the effects as they stand after this tick.
  always_comb begin
    mix = MIXER_ALL_OFF;
    if (a_eff_nx == FX_GAMEOVER || b_eff_nx == FX_GAMEOVER || c_eff_nx == FX_GAMEOVER) begin
      mix = mix & ~8'h07;
    end else if (a_eff_nx == FX_LEVELUP) begin
      mix = mix & ~8'h01;
    end else if (a_eff_nx == FX_BEEP || b_eff_nx == FX_BEEP) begin
      mix = mix & ~8'h03;
    end else begin
      if (a_eff_nx != FX_NONE) mix = mix & ~8'h01;
      if (b_eff_nx == FX_EXP_ENEMY)     mix = mix & ~8'h10;
      else if (b_eff_nx == FX_EXP_SHIP) mix = mix & ~8'h12;
      else if (b_eff_nx != FX_NONE)     mix = mix & ~8'h02;
      if (c_eff_nx == FX_SHOT) mix = mix & ~8'h04;
    end
  end

  // Pack the channel write lists back to back, mixer last.
  always_comb begin
    tick_job = '0;
    n_b      = {1'b0, ch_a.cnt};
    n_c      = n_b + {1'b0, ch_b.cnt};
    n_m      = n_c + {1'b0, ch_c.cnt};
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < ch_a.cnt) tick_job.w[4'(i)] = ch_a.w[i];
    end
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < ch_b.cnt) tick_job.w[n_b + 4'(i)] = ch_b.w[i];
    end
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < ch_c.cnt) tick_job.w[n_c + 4'(i)] = ch_c.w[i];
    end
    tick_job.w[n_m] = '{addr: REG_MIXER, value: mix};
    tick_job.cnt    = n_m + 4'd1;
  end

  always_comb begin
    stop_job       = '0;
    stop_job.cnt   = 4'(JOB_WRITES);
    stop_job.w[0]  = '{addr: REG_MIXER,     value: MIXER_ALL_OFF};
    stop_job.w[1]  = '{addr: REG_VOL_A,     value: 8'd0};
    stop_job.w[2]  = '{addr: REG_VOL_B,     value: 8'd0};
    stop_job.w[3]  = '{addr: REG_VOL_C,     value: 8'd0};
    stop_job.w[4]  = '{addr: REG_TONE_A_LO, value: 8'd0};
    stop_job.w[5]  = '{addr: REG_TONE_A_HI, value: 8'd0};
    stop_job.w[6]  = '{addr: REG_TONE_B_LO, value: 8'd0};
    stop_job.w[7]  = '{addr: REG_TONE_B_HI, value: 8'd0};
    stop_job.w[8]  = '{addr: REG_TONE_C_LO, value: 8'd0};
    stop_job.w[9]  = '{addr: REG_TONE_C_HI, value: 8'd0};
    stop_job.w[10] = '{addr: REG_NOISE,     value: NOISE_IDLE};
  end

  always_comb begin
    a_eff_d = a_eff_q;  a_frm_d = a_frm_q;
    b_eff_d = b_eff_q;  b_frm_d = b_frm_q;
    c_eff_d = c_eff_q;  c_frm_d = c_frm_q;
    push_o  = 1'b0;
    job_o   = tick_job;
    if (accept) begin
      case (in_data_i.kind)
        KIND_TICK: begin
          a_eff_d = a_eff_nx;  a_frm_d = a_frm_nx;
          b_eff_d = b_eff_nx;  b_frm_d = b_frm_nx;
          c_eff_d = c_eff_nx;  c_frm_d = c_frm_nx;
          push_o  = 1'b1;
        end
        KIND_TRIGGER: begin
          case (in_data_i.effect)
            FX_EXP_ENEMY, FX_EXP_SHIP: begin
              b_eff_d = effect_e'(in_data_i.effect);
              b_frm_d = 5'd0;
            end
            FX_SHOT: begin
              c_eff_d = FX_SHOT;
              c_frm_d = 5'd0;
            end
            FX_BEEP, FX_GAMEOVER: begin
              a_eff_d = effect_e'(in_data_i.effect);
              a_frm_d = 5'd0;
              b_eff_d = effect_e'(in_data_i.effect);
              b_frm_d = 5'd0;
            end
            FX_BOSSWARN, FX_LEVELUP: begin
              a_eff_d = effect_e'(in_data_i.effect);
              a_frm_d = 5'd0;
            end
            default: begin
            end
          endcase
        end
        KIND_STOP: begin
          a_eff_d = FX_NONE;  a_frm_d = 5'd0;
          b_eff_d = FX_NONE;  b_frm_d = 5'd0;
          c_eff_d = FX_NONE;  c_frm_d = 5'd0;
          push_o  = 1'b1;
          job_o   = stop_job;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_eff_q <= FX_NONE;  a_frm_q <= 5'd0;
      b_eff_q <= FX_NONE;  b_frm_q <= 5'd0;
      c_eff_q <= FX_NONE;  c_frm_q <= 5'd0;
    end else begin
      a_eff_q <= a_eff_d;  a_frm_q <= a_frm_d;
      b_eff_q <= b_eff_d;  b_frm_q <= b_frm_d;
      c_eff_q <= c_eff_d;  c_frm_q <= c_frm_d;
    end
  end

endmodule

// ===== src/pse_queue.sv =====
// Small register queue of write-list jobs between front end and serializer.
// Depends on pse_pkg.
module pse_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pse_pkg::job_t push_data_i,
  input  logic          pop_i,
  output logic          head_valid_o,
  output pse_pkg::job_t head_o,
  output logic          full_o
);
  import pse_pkg::*;

  job_t                    mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [QUEUE_AW:0]       cnt_q, cnt_d;

  assign head_valid_o = (cnt_q != '0);
  assign full_o       = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/pse_back.sv =====
// Serializer: walks the head job one register write per cycle, while the
// output is ready, into an output register. Depends on pse_pkg.
module pse_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  pse_pkg::job_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pse_pkg::out_t out_data_o
);
  import pse_pkg::*;

  logic [3:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  out_t       data_q, data_d;
  logic       load, is_last;
  write_t     cur;

  assign load    = !valid_q || out_ready_i;
  assign cur     = head_i.w[idx_q];
  assign is_last = (idx_q == head_i.cnt - 4'd1);
  assign pop_o   = load && head_valid_i && is_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    data_d  = data_q;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        data_d = '{reg_addr: cur.addr, reg_value: cur.value, last: is_last};
        idx_d  = is_last ? 4'd0 : idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 4'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== tb/pse_write_checker.sv =====
// Checker for the sound-effect sequencer: watches the request channel, predicts the
// register writes of every accepted request and compares them with the output stream.
// Depends on pse_pkg for the payload structs, the effect codes and the register numbers.
module pse_write_checker
  import pse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  output int unsigned writes_pending_o,
  output int unsigned writes_checked_o,
  output int unsigned mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PRINTED = 100;

  // Mixer enable bits; a cleared bit turns the source on.
  localparam logic [7:0] TONE_A_BIT  = 8'h01;
  localparam logic [7:0] TONE_B_BIT  = 8'h02;
  localparam logic [7:0] TONE_C_BIT  = 8'h04;
  localparam logic [7:0] NOISE_B_BIT = 8'h10;

  // Per-frame tables, entry 0 on the right.
  localparam logic [4:0][7:0] ENEMY_NOISE = {8'h16, 8'h10, 8'h0B, 8'h07, 8'h04};
  localparam logic [4:0][7:0] ENEMY_VOL   = {8'd3, 8'd6, 8'd9, 8'd11, 8'd13};
  localparam logic [6:0][7:0] SHIP_TONE   = {8'd50, 8'd70, 8'd90, 8'd120, 8'd150, 8'd180,
                                             8'd220};
  localparam logic [6:0][7:0] SHIP_VOL    = {8'd4, 8'd6, 8'd8, 8'd10, 8'd12, 8'd14, 8'd15};
  localparam logic [6:0][7:0] SHIP_NOISE  = {8'h1B, 8'h16, 8'h12, 8'h0C, 8'h08, 8'h06,
                                             8'h04};

  effect_e    a_fx, b_fx, c_fx;
  logic [4:0] a_frm, b_frm, c_frm;

  out_t       request_writes[$];
  out_t       writes_due[$];

  task automatic report_mismatch(string msg);
    if (mismatches_o < MAX_PRINTED) begin
      $display("[%0t] MISMATCH %s", $time, msg);
    end
    mismatches_o++;
  endtask

  task automatic add_write(logic [3:0] addr, logic [7:0] value);
    out_t w;
    w.reg_addr  = addr;
    w.reg_value = value;
    w.last      = 1'b0;
    request_writes.push_back(w);
  endtask

  task automatic add_tone(logic [3:0] lo_reg, logic [3:0] vol_reg, logic [7:0] lo,
                          logic [7:0] hi, logic [7:0] vol);
    add_write(lo_reg, lo);
    add_write(lo_reg + 4'd1, hi);
    add_write(vol_reg, vol);
  endtask

  task automatic step_channel_a();
    logic [4:0] f;
    logic       done;
    logic       playing;
    f       = a_frm;
    done    = 1'b0;
    playing = 1'b1;
    case (a_fx)
      FX_BEEP: begin
        if (f < 2) add_tone(REG_TONE_A_LO, REG_VOL_A, 8'd239, 8'd0, 8'd15);
        else if (f == 2) add_write(REG_VOL_A, 8'd0);
        else if (f < 5) add_tone(REG_TONE_A_LO, REG_VOL_A, 8'd190, 8'd0, 8'd15);
        else done = 1'b1;
      end
      FX_LEVELUP: begin
        if (f < 2) add_tone(REG_TONE_A_LO, REG_VOL_A, 8'd239, 8'd0, 8'd14);
        else if (f < 4) add_tone(REG_TONE_A_LO, REG_VOL_A, 8'd190, 8'd0, 8'd14);
        else if (f < 6) add_tone(REG_TONE_A_LO, REG_VOL_A, 8'd160, 8'd0, 8'd13);
        else if (f < 8) add_tone(REG_TONE_A_LO, REG_VOL_A, 8'd119, 8'd0, 8'd15);
        else if (f < 11) add_tone(REG_TONE_A_LO, REG_VOL_A, 8'd119, 8'd0, 8'd7);
        else done = 1'b1;
      end
      FX_GAMEOVER: begin
        if (f < 24) add_tone(REG_TONE_A_LO, REG_VOL_A, 8'd28, 8'd1, 8'd12);
        else done = 1'b1;
      end
      FX_BOSSWARN: begin
        if (f < 2) add_tone(REG_TONE_A_LO, REG_VOL_A, 8'd95, 8'd1, 8'd13);
        else if (f == 2) add_tone(REG_TONE_A_LO, REG_VOL_A, 8'd60, 8'd1, 8'd11);
        else if (f == 3) add_write(REG_VOL_A, 8'd0);
        else if (f < 6) add_tone(REG_TONE_A_LO, REG_VOL_A, 8'd95, 8'd1, 8'd9);
        else done = 1'b1;
      end
      default: playing = 1'b0;
    endcase
    if (!playing) begin
      add_write(REG_VOL_A, 8'd0);
    end else if (done) begin
      a_fx  = FX_NONE;
      a_frm = '0;
      add_write(REG_VOL_A, 8'd0);
    end else begin
      a_frm = a_frm + 5'd1;
    end
  endtask

  task automatic step_channel_b();
    logic [4:0] f;
    logic       done;
    logic       playing;
    f       = b_frm;
    done    = 1'b0;
    playing = 1'b1;
    case (b_fx)
      FX_EXP_ENEMY: begin
        if (f < 5) begin
          add_write(REG_NOISE, ENEMY_NOISE[f[2:0]]);
          add_write(REG_VOL_B, ENEMY_VOL[f[2:0]]);
        end else done = 1'b1;
      end
      FX_EXP_SHIP: begin
        if (f < 7) begin
          add_tone(REG_TONE_B_LO, REG_VOL_B, SHIP_TONE[f[2:0]], 8'd0, SHIP_VOL[f[2:0]]);
          add_write(REG_NOISE, SHIP_NOISE[f[2:0]]);
        end else done = 1'b1;
      end
      FX_BEEP: begin
        if (f < 2) add_tone(REG_TONE_B_LO, REG_VOL_B, 8'd190, 8'd0, 8'd12);
        else if (f == 2) add_write(REG_VOL_B, 8'd0);
        else if (f < 5) add_tone(REG_TONE_B_LO, REG_VOL_B, 8'd159, 8'd0, 8'd12);
        else done = 1'b1;
      end
      FX_GAMEOVER: begin
        if (f < 24) add_tone(REG_TONE_B_LO, REG_VOL_B, 8'd239, 8'd0, 8'd12);
        else done = 1'b1;
      end
      default: playing = 1'b0;
    endcase
    if (!playing) begin
      add_write(REG_VOL_B, 8'd0);
    end else if (done) begin
      b_fx  = FX_NONE;
      b_frm = '0;
      add_write(REG_VOL_B, 8'd0);
    end else begin
      b_frm = b_frm + 5'd1;
    end
  endtask

  task automatic step_channel_c();
    logic [4:0] f;
    logic       done;
    logic       playing;
    f       = c_frm;
    done    = 1'b0;
    playing = 1'b1;
    case (c_fx)
      FX_SHOT: begin
        if (f == 0) add_tone(REG_TONE_C_LO, REG_VOL_C, 8'd160, 8'd0, 8'd9);
        else if (f == 1) add_tone(REG_TONE_C_LO, REG_VOL_C, 8'd112, 8'd0, 8'd4);
        else done = 1'b1;
      end
      // No trigger loads game over into channel C, but the branch is kept.
      FX_GAMEOVER: begin
        if (f < 24) add_tone(REG_TONE_C_LO, REG_VOL_C, 8'd190, 8'd0, 8'd12);
        else done = 1'b1;
      end
      default: playing = 1'b0;
    endcase
    if (!playing) begin
      add_write(REG_VOL_C, 8'd0);
    end else if (done) begin
      c_fx  = FX_NONE;
      c_frm = '0;
      add_write(REG_VOL_C, 8'd0);
    end else begin
      c_frm = c_frm + 5'd1;
    end
  endtask

  // Mixer word from the channel state after the frame has been stepped.
  function automatic logic [7:0] mixer_word();
    logic [7:0] m;
    m = MIXER_ALL_OFF;
    if (a_fx == FX_GAMEOVER || b_fx == FX_GAMEOVER || c_fx == FX_GAMEOVER) begin
      m &= ~(TONE_A_BIT | TONE_B_BIT | TONE_C_BIT);
    end else if (a_fx == FX_LEVELUP) begin
      m &= ~TONE_A_BIT;
    end else if (a_fx == FX_BEEP || b_fx == FX_BEEP) begin
      m &= ~(TONE_A_BIT | TONE_B_BIT);
    end else begin
      if (a_fx != FX_NONE) m &= ~TONE_A_BIT;
      if (b_fx == FX_EXP_ENEMY) m &= ~NOISE_B_BIT;
      else if (b_fx == FX_EXP_SHIP) m &= ~(NOISE_B_BIT | TONE_B_BIT);
      else if (b_fx != FX_NONE) m &= ~TONE_B_BIT;
      if (c_fx == FX_SHOT) m &= ~TONE_C_BIT;
    end
    return m;
  endfunction

  task automatic start_effect(effect_e fx);
    case (fx)
      FX_EXP_ENEMY, FX_EXP_SHIP: begin
        b_fx  = fx;
        b_frm = '0;
      end
      FX_SHOT: begin
        c_fx  = fx;
        c_frm = '0;
      end
      FX_BEEP, FX_GAMEOVER: begin
        a_fx  = fx;
        a_frm = '0;
        b_fx  = fx;
        b_frm = '0;
      end
      FX_BOSSWARN, FX_LEVELUP: begin
        a_fx  = fx;
        a_frm = '0;
      end
      default: ;
    endcase
  endtask

  task automatic silence_channels();
    a_fx  = FX_NONE;
    a_frm = '0;
    b_fx  = FX_NONE;
    b_frm = '0;
    c_fx  = FX_NONE;
    c_frm = '0;
  endtask

  task automatic predict_request_writes(in_t req);
    out_t w;
    request_writes.delete();
    case (req.kind)
      KIND_TICK: begin
        step_channel_a();
        step_channel_b();
        step_channel_c();
        add_write(REG_MIXER, mixer_word());
      end
      KIND_TRIGGER: start_effect(effect_e'(req.effect));
      KIND_STOP: begin
        silence_channels();
        add_write(REG_MIXER, MIXER_ALL_OFF);
        add_write(REG_VOL_A, 8'd0);
        add_write(REG_VOL_B, 8'd0);
        add_write(REG_VOL_C, 8'd0);
        add_write(REG_TONE_A_LO, 8'd0);
        add_write(REG_TONE_A_HI, 8'd0);
        add_write(REG_TONE_B_LO, 8'd0);
        add_write(REG_TONE_B_HI, 8'd0);
        add_write(REG_TONE_C_LO, 8'd0);
        add_write(REG_TONE_C_HI, 8'd0);
        add_write(REG_NOISE, NOISE_IDLE);
      end
      default: ;
    endcase
    if (request_writes.size() > 0) begin
      w      = request_writes.pop_back();
      w.last = 1'b1;
      request_writes.push_back(w);
    end
    foreach (request_writes[i]) writes_due.push_back(request_writes[i]);
  endtask

  task automatic check_write(out_t got);
    out_t want;
    writes_checked_o++;
    if (writes_due.size() == 0) begin
      report_mismatch($sformatf("unexpected write: reg %0d value 0x%02h last %0b",
                                got.reg_addr, got.reg_value, got.last));
    end else begin
      want = writes_due.pop_front();
      if (got.reg_addr !== want.reg_addr || got.reg_value !== want.reg_value ||
          got.last !== want.last) begin
        report_mismatch($sformatf(
          "write %0d: got reg %0d value 0x%02h last %0b, expected reg %0d value 0x%02h last %0b",
          writes_checked_o, got.reg_addr, got.reg_value, got.last,
          want.reg_addr, want.reg_value, want.last));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silence_channels();
      writes_due.delete();
      writes_pending_o <= 0;
      writes_checked_o  = 0;
      mismatches_o      = 0;
    end else begin
      // Results are registered, so a write never belongs to a request taken at the same edge.
      if (out_valid_i && out_ready_i) check_write(out_data_i);
      if (in_valid_i && in_ready_i) predict_request_writes(in_data_i);
      writes_pending_o <= writes_due.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench for the sound-effect sequencer: clock, reset, request stimulus,
// random output stalls, timeout and verdict.
// Depends on pse_pkg, psg_sound_effect_sequencer_top and pse_write_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pse_pkg::*;

  localparam int unsigned RESET_CYCLES    = 10;
  // Least number of requests in the whole run, directed opening and ignored ones included.
  localparam int unsigned RANDOM_REQUESTS = 330;
  // Worst case is roughly 400 requests of 11 writes, each write held off by the
  // longest stall, plus the longest input gaps.
  localparam int unsigned CYCLE_LIMIT     = 600000;
  // Once nothing is expected, give the two-entry job queue time to show any stray write.
  localparam int unsigned DRAIN_CYCLES    = 30;
  // Kind code that the block does not define; it must be swallowed silently.
  localparam logic [1:0]  KIND_SPARE      = 2'd3;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  in_t         in_data_i   = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  out_t        out_data_o;

  int unsigned writes_pending;
  int unsigned writes_checked;
  int unsigned mismatches;

  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  // Cleared during quiet stretches, when neither side idles.
  bit          stalls_on   = 1'b1;
  bit          quiet       = 1'b0;

  int unsigned useful_sent   = 0;
  int unsigned ticks_sent    = 0;
  int unsigned triggers_sent = 0;
  int unsigned stops_sent    = 0;
  int unsigned ignored_sent  = 0;

  psg_sound_effect_sequencer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  pse_write_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .writes_pending_o (writes_pending),
    .writes_checked_o (writes_checked),
    .mismatches_o     (mismatches)
  );

  // 4 ns clock period.
  always #2 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost write ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d writes still expected",
               cycle_count, writes_pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Idle stretch length, drawn from two ranges: mostly the short one, now and then the long one.
  function automatic int unsigned idle_length();
    if ($urandom_range(99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The receiving side stalls at random. A stall is counted down to zero before
  // ready may rise again, so stalls can land on any write of a frame's list.
  always @(posedge clk_i) begin
    if (!stalls_on) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(99) < 70) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= 1'b0;
      stall_left  <= idle_length() - 1;
    end
  end

  // Present one request and hold it until the block takes it. Valid is only
  // dropped when a gap follows, so back-to-back requests keep it high.
  task automatic send_request(logic [1:0] kind, logic [2:0] effect);
    int unsigned gap;
    in_t         req;
    gap = 0;
    if (!quiet && $urandom_range(99) >= 55) gap = idle_length();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.kind   = kind;
    req.effect = effect;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    case (kind)
      KIND_TICK: begin
        ticks_sent++;
        useful_sent++;
      end
      KIND_TRIGGER: begin
        if (effect == FX_NONE) begin
          ignored_sent++;
        end else begin
          triggers_sent++;
          useful_sent++;
        end
      end
      KIND_STOP: begin
        stops_sent++;
        useful_sent++;
      end
      default: ignored_sent++;
    endcase
  endtask

  task automatic send_ticks(int unsigned n);
    repeat (n) send_request(KIND_TICK, 3'($urandom_range(0, 7)));
  endtask

  // One random scene. Most scenes start effects and then play frames, with the
  // odd trigger landing mid-effect; long runs let game over reach its end. The
  // rest are stop-alls, undefined kinds, empty triggers and bare ticks.
  task automatic run_random_scene();
    int unsigned pick;
    int unsigned n;
    quiet     = ($urandom_range(4) == 0);
    stalls_on <= !quiet;
    pick = $urandom_range(99);
    if (pick < 80) begin
      repeat ($urandom_range(1, 3)) send_request(KIND_TRIGGER, 3'($urandom_range(1, 7)));
      n = ($urandom_range(3) == 0) ? $urandom_range(20, 30) : $urandom_range(2, 12);
      repeat (n) begin
        if ($urandom_range(99) < 8) send_request(KIND_TRIGGER, 3'($urandom_range(1, 7)));
        else send_request(KIND_TICK, 3'($urandom_range(0, 7)));
      end
    end else if (pick < 88) begin
      send_request(KIND_STOP, 3'($urandom_range(0, 7)));
    end else if (pick < 94) begin
      send_request(KIND_SPARE, 3'($urandom_range(0, 7)));
    end else if (pick < 97) begin
      send_request(KIND_TRIGGER, FX_NONE);
    end else begin
      send_ticks($urandom_range(1, 5));
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening. Stop-all and a tick on idle channels first, with the
    // effect field set where it must be ignored.
    send_request(KIND_STOP, FX_LEVELUP);
    send_request(KIND_TICK, FX_GAMEOVER);
    // Requests the block must swallow without a write.
    send_request(KIND_TRIGGER, FX_NONE);
    send_request(KIND_SPARE, FX_LEVELUP);
    // Shot on C, enemy blast on B and level up on A all at once.
    send_request(KIND_TRIGGER, FX_SHOT);
    send_request(KIND_TRIGGER, FX_EXP_ENEMY);
    send_request(KIND_TRIGGER, FX_LEVELUP);
    send_ticks(4);
    // Ship blast replaces the enemy blast; boss warning replaces level up.
    send_request(KIND_TRIGGER, FX_EXP_SHIP);
    send_request(KIND_TRIGGER, FX_BOSSWARN);
    send_ticks(4);
    // Beep and game over take both A and B.
    send_request(KIND_TRIGGER, FX_BEEP);
    send_ticks(3);
    send_request(KIND_TRIGGER, FX_GAMEOVER);
    send_ticks(2);
    // Stop-all in the middle of a running effect.
    send_request(KIND_STOP, FX_NONE);

    while (useful_sent + ignored_sent < RANDOM_REQUESTS) run_random_scene();

    in_valid_i <= 1'b0;
    stalls_on  <= 1'b1;
    // The checker's pending count is registered, so let it catch the last request.
    @(posedge clk_i);
    while (writes_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests: %0d frame ticks, %0d effect starts, %0d stop-alls, %0d ignored",
             useful_sent + ignored_sent, ticks_sent, triggers_sent, stops_sent, ignored_sent);
    $display("Compared %0d register writes, %0d mismatches", writes_checked, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
